[hdl/frame_rate_moving_average_unit_defines.svh]
// Assertion macros shared by the frame rate moving average unit
`ifndef FRAME_RATE_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define FRAME_RATE_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FRMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frma assertion failed");

// Next-cycle implication, disabled while in reset
`define FRMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frma assertion failed");

`endif

[hdl/frma_pkg.sv]
// Shared types and constants for the frame rate moving average unit
`default_nettype none

package frma_pkg;

	// Field widths
	localparam int FT_W       = 16;
	localparam int FPS_W      = 10;
	localparam int CATCH_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Default ring depth and the rate ceiling (1000 ms per second)
	localparam int SAMPLES_DEF = 16;
	localparam int RATE_MAX    = 1000;

	// Register reset values
	localparam logic [FT_W-1:0]    THRESH_RST = 16'd10;
	localparam logic [CATCH_W-1:0] CATCH_RST  = 5'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CATCHUP_COUNT  = 1'b1;

	// Operand selection for the shared divider
	typedef enum logic {
		DIV_RATE,
		DIV_AVG_FT
	} div_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE,
		ST_RATE_WAIT,
		ST_CLASSIFY,
		ST_AFT_WAIT,
		ST_READ,
		ST_WRITE,
		ST_AVG,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     take_in;
		logic     rate_max;
		logic     div_start;
		div_sel_t div_sel;
		logic     latch_rate;
		logic     prime;
		logic     wcnt_one;
		logic     wcnt_catch;
		logic     wcnt_cmp;
		logic     ring_read;
		logic     ring_write;
		logic     latch_avg;
		logic     load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ft_zero;
		logic ft_lt2;
		logic primed;
		logic total_zero;
		logic div_done;
		logic wcnt_zero;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

[hdl/frma_if.sv]
// Valid/ready channel interfaces for frame times in and rates out
`default_nettype none

interface frma_in_if;
	logic                        valid;
	logic                        ready;
	logic [frma_pkg::FT_W-1:0]   frame_time_ms;

	modport source (output valid, output frame_time_ms, input ready);
	modport sink   (input valid, input frame_time_ms, output ready);
endinterface

interface frma_out_if;
	logic                        valid;
	logic                        ready;
	logic [frma_pkg::FPS_W-1:0]  avg_fps;
	logic [frma_pkg::FPS_W-1:0]  inst_fps;

	modport source (output valid, output avg_fps, output inst_fps, input ready);
	modport sink   (input valid, input avg_fps, input inst_fps, output ready);
endinterface

`default_nettype wire

[hdl/frma_ram.sv]
// Generic single-port-write, registered-read RAM
`default_nettype none

module frma_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/frma_div.sv]
// Restoring divider, one quotient bit per cycle
`default_nettype none

module frma_div #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic     [W-1:0]  quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	// Shift in next dividend bit and try the subtract
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	// Control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Data: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[hdl/frma_datapath.sv]
// Datapath: config registers, divider, sample ring, running total, output register
`default_nettype none
`include "frame_rate_moving_average_unit_defines.svh"

module frma_datapath #(
	parameter int SAMPLES = frma_pkg::SAMPLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [frma_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [frma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [frma_pkg::FT_W-1:0]        frame_time_ms,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic      [frma_pkg::FPS_W-1:0]       avg_fps,
	output logic      [frma_pkg::FPS_W-1:0]       inst_fps,
	input  wire frma_pkg::cmd_t                   cmd,
	output frma_pkg::status_t                     status
);
	import frma_pkg::*;

	localparam int TOT_MAX = SAMPLES * RATE_MAX;
	localparam int TOT_W   = $clog2(TOT_MAX + 1);
	localparam int DIV_W   = (TOT_W > FT_W) ? TOT_W : FT_W;
	localparam int SLOT_W  = $clog2(SAMPLES);

	// total / SAMPLES as (total * AVG_MUL) >> AVG_SH, exact for any TOT_W-bit total
	localparam int AVG_SH  = TOT_W + $clog2(SAMPLES);
	localparam int AVG_MUL = (2 ** AVG_SH + SAMPLES - 1) / SAMPLES;
	localparam int PROD_W  = 2 * TOT_W + 1;

	localparam logic [DIV_W-1:0]  RATE_NUM  = DIV_W'(RATE_MAX);
	localparam logic [DIV_W-1:0]  AFT_NUM   = DIV_W'(TOT_MAX);
	localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(SAMPLES - 1);
	localparam logic [TOT_W:0]    AVG_RECIP = (TOT_W + 1)'(AVG_MUL);

	logic [FT_W-1:0]    thresh_q;
	logic [CATCH_W-1:0] catch_q;
	logic [FT_W-1:0]    ft_q;
	logic [FPS_W-1:0]   rate_q;
	logic [FPS_W-1:0]   avg_q;
	logic [FPS_W-1:0]   fill_q;
	logic [TOT_W-1:0]   total_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SAMPLES-1:0] valid_q;
	logic               primed_q;
	logic [CATCH_W-1:0] wcnt_q;
	logic               out_valid_q;
	logic [FPS_W-1:0]   out_avg_q;
	logic [FPS_W-1:0]   out_inst_q;

	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic [DIV_W-1:0]   div_quo;
	logic               div_busy;
	logic               div_done;
	logic [FPS_W-1:0]   ram_rdata;
	logic [FPS_W-1:0]   old_rate;
	logic [DIV_W-1:0]   ft_ext;
	logic [DIV_W-1:0]   ft_diff;
	logic               near_avg;
	logic [PROD_W-1:0]  avg_prod;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			catch_q  <= CATCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIFF_THRESHOLD: thresh_q <= cfg_data[FT_W-1:0];
				REG_CATCHUP_COUNT:  catch_q  <= cfg_data[CATCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Divider operand selection
	always_comb begin
		unique case (cmd.div_sel)
			DIV_RATE: begin
				div_dividend = RATE_NUM;
				div_divisor  = DIV_W'(ft_q);
			end
			DIV_AVG_FT: begin
				div_dividend = AFT_NUM;
				div_divisor  = DIV_W'(total_q);
			end
		endcase
	end

	frma_div #(
		.W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sample ring storage
	frma_ram #(
		.WIDTH (FPS_W),
		.DEPTH (SAMPLES)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_write),
		.waddr (slot_q),
		.wdata (rate_q),
		.re    (cmd.ring_read),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// Slots not written since priming hold the priming rate
	assign old_rate = valid_q[slot_q] ? ram_rdata : fill_q;

	// Deviation of the frame time from the average frame time
	assign ft_ext   = DIV_W'(ft_q);
	assign ft_diff  = (div_quo >= ft_ext) ? (div_quo - ft_ext) : (ft_ext - div_quo);
	assign near_avg = (ft_diff <= DIV_W'(thresh_q));

	// Average rate by reciprocal multiply of the running total
	assign avg_prod = PROD_W'(total_q) * PROD_W'(AVG_RECIP);

	// Item payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			ft_q <= frame_time_ms;
		end
		if (cmd.rate_max) begin
			rate_q <= FPS_W'(RATE_MAX);
		end else if (cmd.latch_rate) begin
			rate_q <= div_quo[FPS_W-1:0];
		end
		if (cmd.latch_avg) begin
			avg_q <= avg_prod[AVG_SH +: FPS_W];
		end
	end

	// Ring state: total, slot pointer, valid bits, priming
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			slot_q   <= '0;
			valid_q  <= '0;
			fill_q   <= '0;
			primed_q <= 1'b0;
		end else if (cmd.prime) begin
			total_q  <= TOT_W'(rate_q) * TOT_W'(SAMPLES);
			valid_q  <= '0;
			fill_q   <= rate_q;
			primed_q <= 1'b1;
		end else if (cmd.ring_write) begin
			total_q         <= total_q - TOT_W'(old_rate) + TOT_W'(rate_q);
			valid_q[slot_q] <= 1'b1;
			slot_q          <= (slot_q == SLOT_TOP) ? '0 : slot_q + 1'b1;
		end
	end

	// Remaining ring writes for this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (cmd.wcnt_one) begin
			wcnt_q <= CATCH_W'(1);
		end else if (cmd.wcnt_catch) begin
			wcnt_q <= catch_q;
		end else if (cmd.wcnt_cmp) begin
			wcnt_q <= near_avg ? CATCH_W'(1) : catch_q;
		end else if (cmd.ring_write) begin
			wcnt_q <= wcnt_q - 1'b1;
		end
	end

	// Output register, frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_avg_q  <= avg_q;
			out_inst_q <= rate_q;
		end
	end

	assign out_valid = out_valid_q;
	assign avg_fps   = out_avg_q;
	assign inst_fps  = out_inst_q;

	always_comb begin
		status.ft_zero    = (ft_q == '0);
		status.ft_lt2     = (ft_q < FT_W'(2));
		status.primed     = primed_q;
		status.total_zero = (total_q == '0);
		status.div_done   = div_done;
		status.wcnt_zero  = (wcnt_q == '0);
		status.out_busy   = out_valid_q && !out_ready;
	end

	// Checks
	`FRMA_ASSERT_NOW(a_div_start_idle, clk, arst_n, cmd.div_start, !div_busy)
	`FRMA_ASSERT_NOW(a_total_range, clk, arst_n, 1'b1, total_q <= TOT_W'(TOT_MAX))
	`FRMA_ASSERT_NOW(a_write_counted, clk, arst_n, cmd.ring_write, wcnt_q != '0)
	`FRMA_ASSERT_NOW(a_out_no_overrun, clk, arst_n, cmd.load_out, !(out_valid_q && !out_ready))
	`FRMA_ASSERT_NEXT(a_prime_total, clk, arst_n, cmd.prime, primed_q && valid_q == '0)

endmodule

`default_nettype wire

[hdl/frma_ctrl.sv]
// Controller: sequences rate divide, classification, ring writes and average
`default_nettype none

module frma_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire frma_pkg::status_t   status,
	output frma_pkg::cmd_t           cmd
);
	import frma_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RATE;
			end
			ST_RATE: begin
				state_d = status.ft_zero ? ST_CLASSIFY : ST_RATE_WAIT;
			end
			ST_RATE_WAIT: begin
				if (status.div_done) state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				priority if (!status.primed) state_d = ST_AVG;
				else if (status.ft_lt2 || status.total_zero) state_d = ST_READ;
				else state_d = ST_AFT_WAIT;
			end
			ST_AFT_WAIT: begin
				if (status.div_done) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = status.wcnt_zero ? ST_AVG : ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_READ;
			end
			ST_AVG: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		cmd.div_sel = DIV_RATE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
			end
			ST_RATE: begin
				cmd.rate_max  = status.ft_zero;
				cmd.div_start = !status.ft_zero;
			end
			ST_RATE_WAIT: begin
				cmd.latch_rate = status.div_done;
			end
			ST_CLASSIFY: begin
				cmd.div_sel = DIV_AVG_FT;
				priority if (!status.primed) cmd.prime = 1'b1;
				else if (status.ft_lt2) cmd.wcnt_one = 1'b1;
				else if (status.total_zero) cmd.wcnt_catch = 1'b1;
				else cmd.div_start = 1'b1;
			end
			ST_AFT_WAIT: begin
				cmd.div_sel  = DIV_AVG_FT;
				cmd.wcnt_cmp = status.div_done;
			end
			ST_READ: begin
				cmd.ring_read = !status.wcnt_zero;
			end
			ST_WRITE: begin
				cmd.ring_write = 1'b1;
			end
			ST_AVG: begin
				cmd.latch_avg = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = !status.out_busy;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[hdl/frame_rate_moving_average_unit.sv]
// Top level of the frame rate moving average unit
//
// Takes one frame time (ms) per transaction and returns the instantaneous
// rate 1000/frame_time (1000 for a zero frame time) with the average rate
// over a ring of SAMPLES recent rates. The first transaction after reset
// fills the whole ring with its rate; later ones write the rate once, or
// catchup_count times when the frame time strays from the ring's average
// frame time by more than diff_threshold_ms. Items are processed one at a
// time. The two divisions by a variable (1000/frame_time and
// SAMPLES*1000/total) share one bit-serial divider of
// DIV_W = max(16, clog2(SAMPLES*1000+1)) bits; total/SAMPLES is a
// reciprocal multiply. Each ring write is a registered RAM read, then a
// write. A zero frame time skips the first divide and a fast frame or
// zero total skips the second; the first transaction after reset skips
// the second divide and the ring writes. A finished item waits for the
// output register to be free. The next frame time is accepted while a
// result still sits in the output register. There is no clearing pass
// after reset.
`default_nettype none

module frame_rate_moving_average_unit #(
	parameter int SAMPLES = frma_pkg::SAMPLES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	frma_in_if.sink                              frame_in,
	frma_out_if.source                           rate_out,
	input  wire logic                            cfg_we,
	input  wire logic [frma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [frma_pkg::CFG_DATA_W-1:0] cfg_data
);
	import frma_pkg::*;

	cmd_t    cmd;
	status_t status;

	frma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_in.valid),
		.in_ready (frame_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	frma_datapath #(
		.SAMPLES (SAMPLES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.frame_time_ms (frame_in.frame_time_ms),
		.out_ready     (rate_out.ready),
		.out_valid     (rate_out.valid),
		.avg_fps       (rate_out.avg_fps),
		.inst_fps      (rate_out.inst_fps),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

`default_nettype wire

[verif/frma_rate_checker.sv]
// Predictor and result checker for the frame rate moving average unit
`default_nettype none

module frma_rate_checker
	import frma_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	frma_in_if                         frame_in,
	frma_out_if                        rate_out,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatch_count,
	output int                         pending_count
);

	localparam int DEPTH      = SAMPLES_DEF;
	localparam int RATE_SCALE = RATE_MAX * DEPTH;
	localparam int TOTAL_W    = $clog2(RATE_SCALE + 1);
	localparam int SLOT_W     = $clog2(DEPTH);
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [FPS_W-1:0] avg_fps;
		logic [FPS_W-1:0] inst_fps;
	} rate_pair_t;

	// Expected results, oldest first
	rate_pair_t rate_pairs_due[$];
	rate_pair_t oldest;

	// Shadow of the block's ring, total and registers
	logic [FPS_W-1:0]   rate_ring [DEPTH];
	logic [TOTAL_W-1:0] rate_total;
	logic [SLOT_W-1:0]  write_slot;
	logic               primed;
	logic [FT_W-1:0]    diff_threshold;
	logic [CATCH_W-1:0] catchup_count;
	int                 fail_total;

	// Update the shadow state for one frame time and queue the expected rates
	task automatic predict_rate_pair(input logic [FT_W-1:0] ft);
		logic [FPS_W-1:0] rate;
		int unsigned      writes;
		int unsigned      avg_ft;
		int unsigned      diff;
		rate_pair_t       pair;
		rate   = (ft == '0) ? FPS_W'(RATE_MAX) : FPS_W'(RATE_MAX / int'(ft));
		writes = 0;
		if (!primed) begin
			// first frame seeds every slot
			for (int i = 0; i < DEPTH; i++)
				rate_ring[i] = rate;
			rate_total = TOTAL_W'(DEPTH * int'(rate));
			primed     = 1'b1;
		end else if (ft < 2) begin
			writes = 1;
		end else if (rate_total == '0) begin
			// empty total: no average frame time, always catch up
			writes = catchup_count;
		end else begin
			avg_ft = RATE_SCALE / int'(rate_total);
			diff   = (avg_ft >= ft) ? avg_ft - ft : ft - avg_ft;
			writes = (diff <= diff_threshold) ? 1 : catchup_count;
		end
		// catch-up counts above the depth wrap round the ring
		repeat (writes) begin
			rate_total            = rate_total - TOTAL_W'(rate_ring[write_slot]) + TOTAL_W'(rate);
			rate_ring[write_slot] = rate;
			write_slot            = write_slot + 1'b1;
		end
		pair.avg_fps  = FPS_W'(rate_total / DEPTH);
		pair.inst_fps = rate;
		rate_pairs_due.push_back(pair);
	endtask

	// Watch config writes and both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				rate_ring[i] = '0;
			rate_total     = '0;
			write_slot     = '0;
			primed         = 1'b0;
			diff_threshold = THRESH_RST;
			catchup_count  = CATCH_RST;
			fail_total     = 0;
			rate_pairs_due.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DIFF_THRESHOLD)
					diff_threshold = cfg_data[FT_W-1:0];
				else if (cfg_index == REG_CATCHUP_COUNT)
					catchup_count = cfg_data[CATCH_W-1:0];
			end
			// compare a result transaction with the oldest expectation
			if (rate_out.valid && rate_out.ready) begin
				if (rate_pairs_due.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("unexpected rate result: avg %0d inst %0d",
							rate_out.avg_fps, rate_out.inst_fps);
				end else begin
					oldest = rate_pairs_due.pop_front();
					if (oldest.avg_fps !== rate_out.avg_fps ||
							oldest.inst_fps !== rate_out.inst_fps) begin
						fail_total++;
						if (fail_total <= REPORT_MAX)
							$display("rate mismatch: expected avg %0d inst %0d, got avg %0d inst %0d",
								oldest.avg_fps, oldest.inst_fps,
								rate_out.avg_fps, rate_out.inst_fps);
					end
				end
			end
			if (frame_in.valid && frame_in.ready)
				predict_rate_pair(frame_in.frame_time_ms);
			mismatch_count <= fail_total;
			pending_count  <= rate_pairs_due.size();
		end
	end

endmodule

`default_nettype wire

[verif/tb_frame_rate_moving_average_unit.sv]
// Stimulus and verdict for the frame rate moving average unit
`default_nettype none

module tb_frame_rate_moving_average_unit;
	import frma_pkg::*;

	localparam int NUM_PHASES   = 6;
	localparam int PHASE_ITEMS  = 210;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 200;
	localparam int HOLD_CYCLES  = 500;
	localparam int RUN_LIMIT    = 3000000;

	// Directed frame times; the first one primes the ring with a zero rate
	localparam logic [FT_W-1:0] DIRECTED_FT [22] = '{
		16'd65535, 16'd2000, 16'd0, 16'd1, 16'd2, 16'd3, 16'd16, 16'd1000,
		16'd1001, 16'd500, 16'd33, 16'd33, 16'd33, 16'd17, 16'd100, 16'd50,
		16'd40, 16'd32768, 16'd0, 16'd16, 16'd16, 16'd21845
	};
	localparam logic [FT_W-1:0]    PHASE_THRESH [NUM_PHASES] = '{
		16'd0, 16'd65535, 16'd10, 16'd50, 16'd0, 16'd3
	};
	localparam logic [CATCH_W-1:0] PHASE_CATCH [NUM_PHASES] = '{
		5'd1, 5'd16, 5'd0, 5'd31, 5'd0, 5'd17
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    pending_count;
	int                    results_taken;
	int                    base_ft;
	int                    jitter;

	frma_in_if  frame_ch ();
	frma_out_if rate_ch ();

	frame_rate_moving_average_unit #(.SAMPLES(SAMPLES_DEF)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_in  (frame_ch),
		.rate_out  (rate_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frma_rate_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_in       (frame_ch),
		.rate_out       (rate_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result transactions seen so far, used to trigger the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_taken <= 0;
		else if (rate_ch.valid && rate_ch.ready)
			results_taken <= results_taken + 1;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	// Steady frame times with jitter, plus spikes, fast frames and noise
	function automatic logic [FT_W-1:0] pick_frame_time();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			base_ft = $urandom_range(2, 120);
			jitter  = $urandom_range(0, 25);
		end
		r = $urandom_range(0, 99);
		if (r < 8)
			v = $urandom_range(0, 65535);
		else if (r < 14)
			v = $urandom_range(0, 3);
		else if (r < 17)
			v = $urandom_range(1001, 4000);
		else
			v = base_ft - jitter + int'($urandom_range(0, 2 * jitter));
		if (v < 0)
			v = 0;
		return FT_W'(v);
	endfunction

	// Offer one frame time and wait for its transaction
	task automatic send_frame(input logic [FT_W-1:0] ft);
		int gap;
		@(negedge clk);
		frame_ch.valid         <= 1'b1;
		frame_ch.frame_time_ms <= ft;
		do @(posedge clk); while (!frame_ch.ready);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			frame_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain_results();
		@(negedge clk);
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers; junk in the unused upper bits of the catch-up write
	task automatic program_registers(input logic [FT_W-1:0] thresh,
			input logic [CATCH_W-1:0] catch_n);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DIFF_THRESHOLD;
		cfg_data  <= thresh;
		@(negedge clk);
		cfg_index <= REG_CATCHUP_COUNT;
		cfg_data  <= {junk[CFG_DATA_W-1:CATCH_W], catch_n};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, plus two long hold-offs while frames keep coming
	initial begin
		int stall;
		int hold_left;
		int holds_done;
		stall         = 0;
		hold_left     = 0;
		holds_done    = 0;
		rate_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < 2 && results_taken >= 450 + holds_done * 550) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				rate_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				rate_ch.ready <= 1'b0;
				stall--;
			end else begin
				rate_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Main sequence: reset, directed frames, then random phases per setting
	initial begin
		logic [FT_W-1:0]    thresh;
		logic [CATCH_W-1:0] catch_n;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = REG_DIFF_THRESHOLD;
		cfg_data               = '0;
		frame_ch.valid         = 1'b0;
		frame_ch.frame_time_ms = '0;
		base_ft                = 16;
		jitter                 = 4;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset values of the registers apply here
		foreach (DIRECTED_FT[k])
			send_frame(DIRECTED_FT[k]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			thresh  = PHASE_THRESH[p];
			catch_n = PHASE_CATCH[p];
			if (p == 4) begin
				thresh  = FT_W'($urandom_range(0, 40));
				catch_n = CATCH_W'($urandom_range(0, 31));
			end
			program_registers(thresh, catch_n);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_frame(pick_frame_time());
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#RUN_LIMIT;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
